### sv/mtd_pkg.sv
`default_nettype none
package mtd_pkg;

    // Most result bytes one body byte can cause
    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);

    // Transfer mode codes
    localparam logic [1:0] MODE_PASS = 2'd0;
    localparam logic [1:0] MODE_B64  = 2'd1;
    localparam logic [1:0] MODE_QP   = 2'd2;

    // Quoted-printable escape hold codes
    localparam logic [1:0] HOLD_NONE = 2'd0;
    localparam logic [1:0] HOLD_EQ   = 2'd1;
    localparam logic [1:0] HOLD_TWO  = 2'd2;

    // Group of result bytes caused by one body byte
    typedef struct packed {
        logic [CNT_W-1:0]             cnt;
        logic [MAX_RESULTS-1:0][7:0]  data;
    } t_result_grp;

endpackage
`default_nettype wire

### sv/mtd_decode.sv
`default_nettype none
module mtd_decode (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_valid,
    input  wire logic [1:0]         i_cfg_data,
    input  wire logic               i_take,
    input  wire logic [7:0]         i_byte,
    input  wire logic               i_last,
    output mtd_pkg::t_result_grp    o_grp
);
    import mtd_pkg::*;

    localparam logic [7:0] CHAR_EQ = 8'h3D;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    logic [1:0] r_mode;
    logic [5:0] r_acc, n_acc;
    logic [1:0] r_pairs, n_pairs;
    logic       r_pad, n_pad;
    logic [1:0] r_held, n_held;
    logic [7:0] r_second, n_second;

    // Append one byte to a result group
    function automatic t_result_grp push(input t_result_grp g, input logic [7:0] b);
        t_result_grp r;
        r = g;
        if (g.cnt != CNT_W'(MAX_RESULTS)) begin
            r.data[g.cnt[IDX_W-1:0]] = b;
            r.cnt = g.cnt + CNT_W'(1);
        end
        return r;
    endfunction

    // Base64 alphabet: valid flag and six bits
    function automatic logic [6:0] sixbit_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            t = c - 8'h41;
            return {1'b1, t[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            t = c - 8'h47;
            return {1'b1, t[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            t = c + 8'h04;
            return {1'b1, t[5:0]};
        end else if (c == 8'h2B) begin
            return {1'b1, 6'd62};
        end else if (c == 8'h2F) begin
            return {1'b1, 6'd63};
        end
        return 7'd0;
    endfunction

    // Hex digit of either case: valid flag and nibble
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30;
            return {1'b1, t[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D ||
               c == 8'h0C || c == 8'h0B;
    endfunction

    // Decode one byte against the held state
    always_comb begin
        t_result_grp g;
        logic [6:0]  sx;
        logic [4:0]  nc;
        logic [4:0]  ns;
        g        = '0;
        sx       = sixbit_of(i_byte);
        nc       = nibble_of(i_byte);
        ns       = nibble_of(r_second);
        n_acc    = r_acc;
        n_pairs  = r_pairs;
        n_pad    = r_pad;
        n_held   = r_held;
        n_second = r_second;
        case (r_mode)
            MODE_B64: begin
                if (!r_pad && !is_blank(i_byte)) begin
                    if (i_byte == CHAR_EQ) begin
                        n_pad = 1'b1;
                    end else if (sx[6]) begin
                        case (r_pairs)
                            2'd0: begin
                                n_acc   = sx[5:0];
                                n_pairs = 2'd3;
                            end
                            2'd1: begin
                                g       = push(g, {r_acc[1:0], sx[5:0]});
                                n_acc   = 6'd0;
                                n_pairs = 2'd0;
                            end
                            2'd2: begin
                                g       = push(g, {r_acc[3:0], sx[5:2]});
                                n_acc   = {4'd0, sx[1:0]};
                                n_pairs = 2'd1;
                            end
                            default: begin
                                g       = push(g, {r_acc[5:0], sx[5:4]});
                                n_acc   = {2'd0, sx[3:0]};
                                n_pairs = 2'd2;
                            end
                        endcase
                    end
                end
            end
            MODE_QP: begin
                case (r_held)
                    HOLD_EQ: begin
                        if (i_byte == CHAR_LF) begin
                            n_held = HOLD_NONE;
                        end else if (i_byte == CHAR_CR || nc[4]) begin
                            n_second = i_byte;
                            n_held   = HOLD_TWO;
                        end else begin
                            g = push(g, CHAR_EQ);
                            if (i_byte == CHAR_EQ) begin
                                n_held = HOLD_EQ;
                            end else begin
                                g      = push(g, i_byte);
                                n_held = HOLD_NONE;
                            end
                        end
                    end
                    HOLD_TWO: begin
                        n_held   = HOLD_NONE;
                        n_second = 8'h00;
                        if (r_second == CHAR_CR && i_byte == CHAR_LF) begin
                            // soft line break: drop it
                        end else if (ns[4] && nc[4]) begin
                            g = push(g, {ns[3:0], nc[3:0]});
                        end else begin
                            // malformed escape: emit '=', held byte; recheck new one
                            g = push(g, CHAR_EQ);
                            g = push(g, r_second);
                            if (i_byte == CHAR_EQ) begin
                                n_held = HOLD_EQ;
                            end else begin
                                g = push(g, i_byte);
                            end
                        end
                    end
                    default: begin
                        if (i_byte == CHAR_EQ) begin
                            n_held = HOLD_EQ;
                        end else begin
                            g      = push(g, i_byte);
                            n_held = HOLD_NONE;
                        end
                    end
                endcase
                // flush held escape bytes at message end
                if (i_last) begin
                    if (n_held == HOLD_EQ) begin
                        g = push(g, CHAR_EQ);
                    end else if (n_held == HOLD_TWO) begin
                        g = push(g, CHAR_EQ);
                        g = push(g, n_second);
                    end
                end
            end
            default: begin
                g = push(g, i_byte);
            end
        endcase
        if (i_last) begin
            n_acc    = 6'd0;
            n_pairs  = 2'd0;
            n_pad    = 1'b0;
            n_held   = HOLD_NONE;
            n_second = 8'h00;
        end
        o_grp = g;
    end

    // Hold the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_PASS;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    // Advance decoder state on each taken byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= 6'd0;
            r_pairs  <= 2'd0;
            r_pad    <= 1'b0;
            r_held   <= HOLD_NONE;
            r_second <= 8'h00;
        end else if (i_take) begin
            r_acc    <= n_acc;
            r_pairs  <= n_pairs;
            r_pad    <= n_pad;
            r_held   <= n_held;
            r_second <= n_second;
        end
    end

`ifndef SYNTHESIS
    a_held_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held == HOLD_NONE || r_held == HOLD_EQ || r_held == HOLD_TWO)
        else $error("escape hold code out of range");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && i_last |=> r_held == HOLD_NONE && !r_pad && r_pairs == 2'd0)
        else $error("state not cleared after message end");
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_take |=> $stable(r_held) && $stable(r_pairs) && $stable(r_pad))
        else $error("state moved without a taken byte");
`endif

endmodule
`default_nettype wire

### sv/mtd_out_buf.sv
`default_nettype none
module mtd_out_buf (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire mtd_pkg::t_result_grp  i_grp,
    output logic                       o_free,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    output logic [7:0]                 o_m_axis_tdata,   // out_byte [7:0]
    output logic                       o_m_axis_tlast    // run_last
);
    import mtd_pkg::*;

    logic [CNT_W-1:0]            r_cnt;
    logic [IDX_W-1:0]            r_idx;
    logic [MAX_RESULTS-1:0][7:0] r_data;
    logic                        w_last;
    logic                        w_done;

    // Drive the current result byte
    assign w_last          = (CNT_W'(r_idx) + CNT_W'(1)) == r_cnt;
    assign o_m_axis_tvalid = r_cnt != '0;
    assign o_m_axis_tdata  = r_data[r_idx];
    assign o_m_axis_tlast  = w_last;
    assign w_done          = o_m_axis_tvalid && i_m_axis_tready && w_last;
    assign o_free          = (r_cnt == '0) || w_done;

    // Load a group, advance per delivered byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_grp.cnt;
            r_idx <= '0;
        end else if (w_done) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (o_m_axis_tvalid && i_m_axis_tready) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_grp.data;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != '0 |-> CNT_W'(r_idx) < r_cnt)
        else $error("result index beyond group");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free && i_grp.cnt != '0)
        else $error("group loaded over pending results");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_RESULTS))
        else $error("result count too large");
`endif

endmodule
`default_nettype wire

### sv/mime_transfer_decoder_unit.sv
`default_nettype none
// MIME body decoder: takes one encoded body byte per request and returns zero to three
// decoded bytes, in pass-through, base64 or quoted-printable mode as set by the mode
// register (write it only while the block is idle). While the output is ready, the
// result buffer sends one byte per cycle, and a byte is accepted every cycle if it
// yields at most one result; a byte with several results holds the output until all
// are sent, stalling the input register. Bytes that yield nothing pass without waiting
// on the output. Each byte goes through the input register, then the result buffer.
// tlast on the output marks the last result caused by one input byte; tlast on the input
// marks the end of the body, which flushes held escape bytes and clears the decoding state.
module mime_transfer_decoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_data,       // transfer_mode [1:0]
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // in_byte [7:0]
    input  wire logic        i_s_axis_tlast,   // message_last
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // out_byte [7:0]
    output logic             o_m_axis_tlast    // run_last
);
    import mtd_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        w_take;
    logic        w_free;
    t_result_grp w_grp;

    assign o_cfg_ready = 1'b1;

    // Consume the held byte when its results fit in the buffer
    assign w_take          = r_in_valid && (w_grp.cnt == '0 || w_free);
    assign o_s_axis_tready = !r_in_valid || w_take;

    // Hold the input request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    mtd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_take      (w_take),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .o_grp       (w_grp)
    );

    mtd_out_buf u_out_buf (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_load          (w_take && w_grp.cnt != '0),
        .i_grp           (w_grp),
        .o_free          (w_free),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule
`default_nettype wire
